FILE: hw/rtl/assert_macros.svh
// Assertion helpers included by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/mstk_pkg.sv
`timescale 1ns / 1ps
package mstk_pkg;
   typedef struct packed {
      logic [3:0]  end_a;
      logic [3:0]  end_b;
      logic [15:0] edge_weight;
      logic        final_edge;
   } req_type;

   typedef struct packed {
      logic [3:0]  pick_a;
      logic [3:0]  pick_b;
      logic [15:0] pick_weight;
      logic        last_pick;
      logic        empty_tree;
      logic        dropped_edges;
   } rsp_type;

   // Classified word handed from the front to the back part.
   typedef struct packed {
      logic [3:0]  end_a;
      logic [3:0]  end_b;
      logic [15:0] edge_weight;
      logic        keep;
      logic        final_edge;
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_SET_INIT,
      ST_SCAN_RD,
      ST_SCAN_WAIT,
      ST_FIND,
      ST_COMPRESS,
      ST_DECIDE,
      ST_EMIT,
      ST_FINISH
   } back_state_type;
endpackage

FILE: hw/rtl/minimum_spanning_tree_kruskal.sv
// Flow: an edge passes the front register and the queue; the back part then
// writes it into an empty store directly, else first moves larger entries up.
// The last edge starts a scan that reads the stored edges in order, walks parent
// links and emits each pick, held by result stalls; the last pick leaves at the end.
// Loading: the back part takes a new edge only once the last one is inserted.
// Reset: synchronous, active high; clears edge count and drop flag, resets union-find.
`timescale 1ns / 1ps
module minimum_spanning_tree_kruskal #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_EDGES    = 128,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mstk_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mstk_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [4:0]        csr_wdata
);
   import mstk_pkg::*;

   logic [4:0] vcount_ff;
   logic       f_valid, f_ready, b_valid, b_ready;
   cmd_type    f_data, b_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         vcount_ff <= 5'd16;
      end else if (csr_write) begin
         vcount_ff <= csr_wdata;
      end
   end

   mstk_front #(.MAX_VERTICES(MAX_VERTICES), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .vcount(vcount_ff), .cmd_valid(f_valid), .cmd_ready(f_ready), .cmd_data(f_data)
   );

   mstk_queue #(.DEPTH(4)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   mstk_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_back (
      .clock, .reset, .cmd_valid(b_valid), .cmd_ready(b_ready), .cmd_data(b_data),
      .vcount(vcount_ff), .rsp_valid, .rsp_ready, .rsp_data
   );
endmodule

FILE: hw/rtl/mstk_ram.sv
`timescale 1ns / 1ps
module mstk_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hw/rtl/mstk_front.sv
`timescale 1ns / 1ps
module mstk_front #(
   parameter int MAX_VERTICES = 16,
   parameter int WEIGHT_BITS  = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  mstk_pkg::req_type  req_data,
   input  logic [4:0]         vcount,
   output logic               cmd_valid,
   input  logic               cmd_ready,
   output mstk_pkg::cmd_type  cmd_data
);
   import mstk_pkg::*;

   localparam int VcW = $clog2(MAX_VERTICES + 1);

   logic [VcW:0]    eff_n;
   logic [VcW:0]    vc_ext;
   logic [VcW:0]    a_ext;
   logic [VcW:0]    b_ext;
   logic [15:0]     wmask;
   logic            full_ff;
   logic            full_in;
   cmd_type         cmd_ff;
   cmd_type         cmd_in;

   always_comb begin
      vc_ext = (VcW + 1)'(vcount);
      eff_n  = (vc_ext > (VcW + 1)'(MAX_VERTICES)) ? (VcW + 1)'(MAX_VERTICES) : vc_ext;
      a_ext  = (VcW + 1)'(req_data.end_a);
      b_ext  = (VcW + 1)'(req_data.end_b);
      for (int i = 0; i < 16; i++) begin
         wmask[i] = (i < WEIGHT_BITS);
      end
      cmd_in.end_a       = req_data.end_a;
      cmd_in.end_b       = req_data.end_b;
      cmd_in.edge_weight = req_data.edge_weight & wmask;
      cmd_in.final_edge  = req_data.final_edge;
      cmd_in.keep        = (a_ext < eff_n) && (b_ext < eff_n);
   end

   // One-deep holding register; capacity checks happen in the back part.
   assign req_ready = !full_ff || cmd_ready;
   assign cmd_valid = full_ff;
   assign cmd_data  = cmd_ff;

   always_comb begin
      full_in = full_ff;
      if (cmd_ready && full_ff) begin
         full_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         full_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end
endmodule

FILE: hw/rtl/mstk_queue.sv
`timescale 1ns / 1ps
module mstk_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  mstk_pkg::cmd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output mstk_pkg::cmd_type out_data
);
   import mstk_pkg::*;

   localparam int AW = $clog2(DEPTH);

   cmd_type       slot_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic          push, pop;

   assign in_ready  = (cnt_ff != (AW + 1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_data  = slot_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ((wp_ff == AW'(DEPTH - 1)) ? '0 : wp_ff + 1'b1) : wp_ff;
      rp_in  = pop ? ((rp_ff == AW'(DEPTH - 1)) ? '0 : rp_ff + 1'b1) : rp_ff;
      cnt_in = cnt_ff + (AW + 1)'(push) - (AW + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         slot_ff[wp_ff] <= in_data;
      end
   end
endmodule

FILE: hw/rtl/mstk_back.sv
`timescale 1ns / 1ps
module mstk_back #(
   parameter int MAX_VERTICES = 16,
   parameter int MAX_EDGES    = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  mstk_pkg::cmd_type cmd_data,
   input  logic [4:0]        vcount,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mstk_pkg::rsp_type rsp_data
);
   import mstk_pkg::*;

   localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
   localparam int ECW = $clog2(MAX_EDGES + 1);
   localparam int VW  = $clog2(MAX_VERTICES);
   localparam int SW  = $clog2(MAX_VERTICES + 1);
   localparam int VcW = $clog2(MAX_VERTICES + 1);
   localparam int EW  = 24;

   back_state_type state_ff, state_in;

   logic [ECW-1:0] count_ff, count_in;
   logic [ECW-1:0] pos_ff, pos_in;
   logic           drop_ff, drop_in;
   cmd_type        cur_ff, cur_in;
   logic [VW-1:0]  par_ff [MAX_VERTICES];
   logic [SW-1:0]  size_ff [MAX_VERTICES];
   logic [VW-1:0]  vtx_ff, vtx_in;
   logic [VW-1:0]  ra_ff, ra_in;
   logic           side_ff, side_in;
   logic [VW-1:0]  walk_ff, walk_in;
   logic [SW-1:0]  picks_ff, picks_in;
   logic [SW-1:0]  limit_ff, limit_in;
   logic [EW-1:0]  edge_ff, edge_in;
   logic [EW-1:0]  pend_ff, pend_in;
   rsp_type        out_ff, out_in;
   logic           out_full_ff, out_full_in;

   logic           ram_we;
   logic [EAW-1:0] ram_wa, ram_ra;
   logic [EW-1:0]  ram_wd, ram_rd;

   logic           par_we;
   logic [VW-1:0]  par_wa, par_wd;
   logic           join_en;
   logic [VW-1:0]  join_r1, join_r2;
   logic           set_init;
   logic [VcW:0]   eff_n, vc_ext;
   logic [3:0]     ram_a;
   logic [15:0]    ram_w;

   mstk_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign ram_a = ram_rd[23:20];
   assign ram_w = ram_rd[15:0];
   assign rsp_valid = out_full_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      vc_ext = (VcW + 1)'(vcount);
      eff_n  = (vc_ext > (VcW + 1)'(MAX_VERTICES)) ? (VcW + 1)'(MAX_VERTICES) : vc_ext;
   end

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      pos_in      = pos_ff;
      drop_in     = drop_ff;
      cur_in      = cur_ff;
      vtx_in      = vtx_ff;
      ra_in       = ra_ff;
      side_in     = side_ff;
      walk_in     = walk_ff;
      picks_in    = picks_ff;
      limit_in    = limit_ff;
      edge_in     = edge_ff;
      pend_in     = pend_ff;
      out_in      = out_ff;
      out_full_in = out_full_ff;
      cmd_ready   = 1'b0;
      ram_we      = 1'b0;
      ram_wa      = pos_ff[EAW-1:0];
      ram_wd      = {cur_ff.end_a, cur_ff.end_b, cur_ff.edge_weight};
      ram_ra      = pos_ff[EAW-1:0] - 1'b1;
      par_we      = 1'b0;
      par_wa      = walk_ff;
      par_wd      = ra_ff;
      join_en     = 1'b0;
      join_r1     = ra_ff;
      join_r2     = vtx_ff;
      set_init    = 1'b0;

      if (rsp_ready && out_full_ff) begin
         out_full_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               cur_in = cmd_data;
               pos_in = count_ff;
               if (!cmd_data.keep || count_ff == ECW'(MAX_EDGES)) begin
                  drop_in  = 1'b1;
                  state_in = cmd_data.final_edge ? ST_SET_INIT : ST_IDLE;
               end else begin
                  count_in = count_ff + 1'b1;
                  state_in = ST_SHIFT_RD;
               end
            end
         end
         // Insertion: read the entry below, move it up while its weight is larger.
         ST_SHIFT_RD: begin
            if (pos_ff == '0) begin
               ram_we   = 1'b1;
               state_in = cur_ff.final_edge ? ST_SET_INIT : ST_IDLE;
            end else begin
               state_in = ST_SHIFT_WR;
            end
         end
         ST_SHIFT_WR: begin
            ram_we = 1'b1;
            if (ram_w > cur_ff.edge_weight) begin
               ram_wd   = ram_rd;
               pos_in   = pos_ff - 1'b1;
               state_in = ST_SHIFT_RD;
            end else begin
               state_in = cur_ff.final_edge ? ST_SET_INIT : ST_IDLE;
            end
         end
         ST_SET_INIT: begin
            set_init = 1'b1;
            pos_in   = '0;
            picks_in = '0;
            limit_in = (eff_n == '0) ? '0 : SW'(eff_n - 1'b1);
            state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: begin
            ram_ra = pos_ff[EAW-1:0];
            if (pos_ff == count_ff || picks_ff == limit_ff) begin
               state_in = ST_FINISH;
            end else begin
               state_in = ST_SCAN_WAIT;
            end
         end
         ST_SCAN_WAIT: begin
            edge_in  = ram_rd;
            vtx_in   = VW'(ram_a);
            walk_in  = VW'(ram_a);
            side_in  = 1'b0;
            state_in = ST_FIND;
         end
         // Follow the parent chain one link a cycle.
         ST_FIND: begin
            if (par_ff[vtx_ff] == vtx_ff) begin
               if (!side_ff) begin
                  ra_in = vtx_ff;
               end
               state_in = ST_COMPRESS;
            end else begin
               vtx_in = par_ff[vtx_ff];
            end
         end
         // Point each node on the path at the root, one a cycle.
         ST_COMPRESS: begin
            if (walk_ff == vtx_ff) begin
               if (!side_ff) begin
                  side_in = 1'b1;
                  vtx_in  = VW'(edge_ff[19:16]);
                  walk_in = VW'(edge_ff[19:16]);
                  state_in = ST_FIND;
               end else begin
                  state_in = ST_DECIDE;
               end
            end else begin
               par_we  = 1'b1;
               par_wa  = walk_ff;
               par_wd  = vtx_ff;
               walk_in = par_ff[walk_ff];
            end
         end
         ST_DECIDE: begin
            pos_in = pos_ff + 1'b1;
            if (ra_ff != vtx_ff) begin
               join_en  = 1'b1;
               picks_in = picks_ff + 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_SCAN_RD;
            end
         end
         // Hold the newest pick back so the end of the scan can mark it last.
         ST_EMIT: begin
            if (picks_ff == SW'(1)) begin
               pend_in  = edge_ff;
               state_in = ST_SCAN_RD;
            end else if (!out_full_in) begin
               out_in.pick_a        = pend_ff[23:20];
               out_in.pick_b        = pend_ff[19:16];
               out_in.pick_weight   = pend_ff[15:0];
               out_in.empty_tree    = 1'b0;
               out_in.last_pick     = 1'b0;
               out_in.dropped_edges = drop_ff;
               out_full_in          = 1'b1;
               pend_in              = edge_ff;
               state_in             = ST_SCAN_RD;
            end
         end
         ST_FINISH: begin
            if (!out_full_in) begin
               if (picks_ff == '0) begin
                  out_in.pick_a      = '0;
                  out_in.pick_b      = '0;
                  out_in.pick_weight = '0;
                  out_in.empty_tree  = 1'b1;
               end else begin
                  out_in.pick_a      = pend_ff[23:20];
                  out_in.pick_b      = pend_ff[19:16];
                  out_in.pick_weight = pend_ff[15:0];
                  out_in.empty_tree  = 1'b0;
               end
               out_in.last_pick     = 1'b1;
               out_in.dropped_edges = drop_ff;
               out_full_in          = 1'b1;
               count_in             = '0;
               drop_in              = 1'b0;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         drop_ff     <= 1'b0;
         out_full_ff <= 1'b0;
         for (int v = 0; v < MAX_VERTICES; v++) begin
            par_ff[v]  <= VW'(v);
            size_ff[v] <= SW'(1);
         end
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         drop_ff     <= drop_in;
         out_full_ff <= out_full_in;
         if (set_init) begin
            for (int v = 0; v < MAX_VERTICES; v++) begin
               par_ff[v]  <= VW'(v);
               size_ff[v] <= SW'(1);
            end
         end else if (join_en) begin
            if (size_ff[join_r1] < size_ff[join_r2]) begin
               size_ff[join_r2] <= size_ff[join_r2] + size_ff[join_r1];
               par_ff[join_r1]  <= join_r2;
            end else begin
               size_ff[join_r1] <= size_ff[join_r1] + size_ff[join_r2];
               par_ff[join_r2]  <= join_r1;
            end
         end else if (par_we) begin
            par_ff[par_wa] <= par_wd;
         end
      end
      pos_ff   <= pos_in;
      cur_ff   <= cur_in;
      vtx_ff   <= vtx_in;
      ra_ff    <= ra_in;
      side_ff  <= side_in;
      walk_ff  <= walk_in;
      picks_ff <= picks_in;
      limit_ff <= limit_in;
      edge_ff  <= edge_in;
      pend_ff  <= pend_in;
      out_ff   <= out_in;
   end
endmodule

FILE: hw/rtl/mstk_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mstk_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input mstk_pkg::rsp_type rsp_data
);
   import mstk_pkg::*;

   logic empty_word;
   logic rsp_stall;

   assign empty_word = rsp_valid && rsp_data.empty_tree;
   assign rsp_stall  = rsp_valid && !rsp_ready;

   `CHK_IMPLY(empty_is_last, clock, reset, !empty_word || rsp_data.last_pick, "empty not last")
   `CHK_IMPLY(empty_zero, clock, reset, !empty_word || (rsp_data.pick_weight == '0), "empty wt")
   `CHK_NEXT(rsp_hold, clock, reset, rsp_stall, rsp_valid && $stable(rsp_data), "rsp moved")
endmodule

bind minimum_spanning_tree_kruskal mstk_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_data
);

FILE: dv/tb_minimum_spanning_tree_kruskal.sv
`timescale 1ns / 1ps
module tb_minimum_spanning_tree_kruskal;
   import mstk_pkg::*;

   localparam int NumVert  = 16;
   localparam int EdgeCap  = 128;
   localparam int WdogMax  = 200000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic    csr_write = 1'b0;
   logic [4:0] csr_wdata = '0;

   minimum_spanning_tree_kruskal DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_write(csr_write), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   req_type    sorted_edges[$];
   logic [4:0] vert_count = 5'd16;
   logic       drop_flag = 1'b0;
   logic [3:0] parent_of[NumVert];
   logic [4:0] size_of[NumVert];
   rsp_type    tree_picks[$];

   int  mismatches = 0;
   bit  idle_on = 1'b1;
   bit  hold_rsp = 1'b0;
   int  quiet_cycles = 0;

   function automatic logic [3:0] find_root(logic [3:0] v);
      logic [3:0] r, nx;
      int g;
      r = v;
      g = 0;
      while (parent_of[r] != r && g < NumVert) begin
         r = parent_of[r];
         g++;
      end
      g = 0;
      while (v != r && g < NumVert) begin
         nx = parent_of[v];
         parent_of[v] = r;
         v = nx;
         g++;
      end
      return r;
   endfunction

   task automatic predict_edge(req_type e);
      int n, limit, picks, pos;
      logic [3:0] r1, r2;
      rsp_type p;
      n = (vert_count > NumVert) ? NumVert : vert_count;
      if (e.end_a >= n || e.end_b >= n || sorted_edges.size() >= EdgeCap)
         drop_flag = 1'b1;
      else begin
         pos = sorted_edges.size();
         while (pos > 0 && sorted_edges[pos-1].edge_weight > e.edge_weight) pos--;
         sorted_edges.insert(pos, e);
      end
      if (!e.final_edge) return;
      for (int v = 0; v < NumVert; v++) begin
         parent_of[v] = 4'(v);
         size_of[v] = 5'd1;
      end
      limit = (n > 0) ? n - 1 : 0;
      picks = 0;
      for (int i = 0; i < sorted_edges.size() && picks < limit; i++) begin
         r1 = find_root(sorted_edges[i].end_a);
         r2 = find_root(sorted_edges[i].end_b);
         if (r1 != r2) begin
            p = '0;
            p.pick_a = sorted_edges[i].end_a;
            p.pick_b = sorted_edges[i].end_b;
            p.pick_weight = sorted_edges[i].edge_weight;
            p.last_pick = (picks + 1 == limit);
            p.dropped_edges = drop_flag;
            tree_picks.push_back(p);
            picks++;
            if (size_of[r1] < size_of[r2]) begin
               size_of[r2] += size_of[r1];
               parent_of[r1] = r2;
            end else begin
               size_of[r1] += size_of[r2];
               parent_of[r2] = r1;
            end
         end
      end
      if (picks == 0) begin
         p = '0;
         p.last_pick = 1'b1;
         p.empty_tree = 1'b1;
         p.dropped_edges = drop_flag;
         tree_picks.push_back(p);
      end else
         tree_picks[tree_picks.size()-1].last_pick = 1'b1;
      sorted_edges.delete();
      drop_flag = 1'b0;
   endtask

   task automatic send_edge(logic [3:0] a, logic [3:0] b, logic [15:0] w, logic fin);
      req_type e;
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      e.end_a = a;
      e.end_b = b;
      e.edge_weight = w;
      e.final_edge = fin;
      req_data <= e;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_edge(e);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tree_picks.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   task automatic set_vertices(logic [4:0] n);
      drain();
      csr_wdata <= n;
      csr_write <= 1'b1;
      @(posedge clock);
      csr_write <= 1'b0;
      vert_count = n;
   endtask

   task automatic send_graph(int n_edges, int n_vert, bit allow_bad);
      int hi;
      hi = (allow_bad || n_vert == 0) ? 15 : n_vert - 1;
      for (int i = 0; i < n_edges; i++)
         send_edge(4'($urandom_range(0, hi)), 4'($urandom_range(0, hi)),
            ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 7)) : 16'($urandom),
            i == n_edges - 1);
   endtask

   // result side: random stalls, checked against oldest expectation
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (hold_rsp) rsp_ready <= 1'b0;
      else if (!idle_on) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (tree_picks.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", rsp_data);
         end else begin
            if (rsp_data !== tree_picks[0]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected %p, got %p", tree_picks[0], rsp_data);
            end
            void'(tree_picks.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WdogMax) begin
         $display("tb_minimum_spanning_tree_kruskal: done, errors");
         $finish;
      end
   end

   task automatic test_directed();
      send_edge(4'd0, 4'd15, 16'hFFFF, 1'b0);
      send_edge(4'd15, 4'd1, 16'h0000, 1'b0);
      send_edge(4'd3, 4'd3, 16'd5, 1'b0);        // self loop
      send_edge(4'd1, 4'd2, 16'd7, 1'b0);
      send_edge(4'd2, 4'd3, 16'd7, 1'b0);        // tie keeps arrival order
      send_edge(4'd1, 4'd3, 16'd7, 1'b1);
      send_edge(4'd4, 4'd4, 16'd9, 1'b1);        // only a self loop: empty
      set_vertices(5'd4);
      send_edge(4'd0, 4'd1, 16'h5555, 1'b0);
      send_edge(4'd4, 4'd1, 16'd1, 1'b0);        // bad vertex
      send_edge(4'd2, 4'd3, 16'hAAAA, 1'b0);
      send_edge(4'd1, 4'd2, 16'd3, 1'b1);
      send_edge(4'd9, 4'd0, 16'd2, 1'b1);        // drop on final edge, empty run
      set_vertices(5'd0);
      send_edge(4'd0, 4'd0, 16'd1, 1'b1);
      set_vertices(5'd1);
      send_edge(4'd0, 4'd0, 16'd1, 1'b1);
      set_vertices(5'd31);                       // saturates to 16
      send_edge(4'd15, 4'd14, 16'd8, 1'b1);
   endtask

   task automatic test_store_full();
      set_vertices(5'd16);
      for (int i = 0; i < EdgeCap + 3; i++)
         send_edge(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
            16'($urandom_range(0, 40)), i == EdgeCap + 2);
   endtask

   task automatic test_random();
      logic [4:0] nv;
      for (int g = 0; g < 10; g++) begin
         nv = (g % 3 == 0) ? 5'd16 : 5'($urandom_range(2, 16));
         set_vertices(nv);
         send_graph($urandom_range(3, 20), nv, $urandom_range(0, 4) == 0);
      end
   endtask

   task automatic test_backpressure();
      set_vertices(5'd16);
      fork
         begin
            hold_rsp = 1'b1;
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int g = 0; g < 3; g++) send_graph(10, 16, 1'b0);
      join
   endtask

   task automatic test_no_idle();
      idle_on = 1'b0;
      set_vertices(5'd12);
      for (int g = 0; g < 3; g++) send_graph(10, 12, 1'b0);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_store_full();
      test_random();
      test_backpressure();
      test_no_idle();
      drain();
      if (mismatches == 0 && tree_picks.size() == 0)
         $display("tb_minimum_spanning_tree_kruskal: done, clean");
      else
         $display("tb_minimum_spanning_tree_kruskal: done, errors");
      $finish;
   end
endmodule
